// File: sv/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and helpers of the Base64 stream decoder
// Holds the status codes, the classified character record that travels
// from the front to the back, and the alphabet decode function.
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_LENGTH  = 2'd1,
      ST_ILLEGAL = 2'd2,
      ST_PADDING = 2'd3
   } status_type;

   localparam logic [7:0] PAD_CODE = 8'h3D;
   localparam int unsigned QUEUE_DEPTH = 2;

   // one classified character, as the back part consumes it
   typedef struct packed {
      logic [5:0] sextet;   // 0 for pad and for illegal characters
      logic       is_pad;
      logic       illegal;
      logic       last;
   } entry_type;

   // map an ASCII code onto the standard alphabet; bit 6 flags a hit
   function automatic logic [6:0] sextet_of(input logic [7:0] code);
      logic [7:0] t;
      logic [6:0] r;
      t = 8'd0;
      r = 7'd0;
      if (code >= 8'h41 && code <= 8'h5A) begin
         t = code - 8'd65;
         r = {1'b1, t[5:0]};
      end else if (code >= 8'h61 && code <= 8'h7A) begin
         t = code - 8'd71;
         r = {1'b1, t[5:0]};
      end else if (code >= 8'h30 && code <= 8'h39) begin
         t = code + 8'd4;
         r = {1'b1, t[5:0]};
      end else if (code == 8'h2B) begin
         r = {1'b1, 6'd62};
      end else if (code == 8'h2F) begin
         r = {1'b1, 6'd63};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: sv/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front: request intake and character classification
// Accepts one character per cycle while the queue has room and turns it into a classified record.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_front import b64d_pkg::*; (
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] char_code
   input  wire logic       req_tlast,   // last_char
   input  wire logic       queue_full,
   output logic            push_valid,
   output entry_type       push_entry
);

   logic [6:0] hit;
   logic       pad;

   always_comb begin
      hit = sextet_of(req_tdata);
      pad = (req_tdata == PAD_CODE);
      push_entry.sextet  = hit[5:0];
      push_entry.is_pad  = pad;
      push_entry.illegal = !hit[6] && !pad;
      push_entry.last    = req_tlast;
   end

   // take a request whenever the queue has room
   assign req_tready = !queue_full;
   assign push_valid = req_tvalid && !queue_full;

endmodule

`default_nettype wire

// File: sv/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue: short queue between front and back
// Two-entry FIFO of classified characters; push and pop in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_queue import b64d_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_valid,
   input  wire entry_type push_entry,
   output logic           full,
   input  wire logic      pop,
   output logic           pop_valid,
   output entry_type      pop_entry
);

   entry_type  slot_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != 2'd0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_valid;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push_valid) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// File: sv/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back: group decoding and result register
// Tracks the group position, leftover sextet, padding and sticky status,
// and drives the registered response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_back import b64d_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      pop_valid,
   input  wire entry_type pop_entry,
   output logic           pop,
   output logic           rsp_tvalid,
   input  wire logic      rsp_tready,
   output logic [7:0]     rsp_tdata,   // [7:0] data_byte
   output logic           rsp_tlast,   // end_of_message
   output logic [2:0]     rsp_tuser    // [0] byte_present, [2:1] status
);

   logic [1:0] pos_ff, pos_in;
   logic [5:0] prev_ff, prev_in;
   logic       pad_seen_ff, pad_seen_in;
   status_type sticky_ff, sticky_in;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_present_ff, out_present_in;
   logic       out_last_ff, out_last_in;
   status_type out_status_ff, out_status_in;

   logic       emit;
   logic [7:0] byte_val;
   status_type st;

   // advance when the result slot is free or being drained
   assign pop = pop_valid && (!out_valid_ff || rsp_tready);

   always_comb begin
      emit        = 1'b0;
      byte_val    = 8'd0;
      st          = sticky_ff;
      pad_seen_in = pad_seen_ff;

      if (pop_entry.is_pad) begin
         if (pos_ff < 2'd2) begin
            if (st == ST_OK) st = ST_PADDING;
         end else begin
            pad_seen_in = 1'b1;
         end
      end else begin
         if (pop_entry.illegal && st == ST_OK) st = ST_ILLEGAL;
         if (pad_seen_ff && st == ST_OK) st = ST_PADDING;
         case (pos_ff)
            2'd1: begin
               emit     = 1'b1;
               byte_val = {prev_ff, pop_entry.sextet[5:4]};
            end
            2'd2: begin
               emit     = 1'b1;
               byte_val = {prev_ff[3:0], pop_entry.sextet[5:2]};
            end
            2'd3: begin
               emit     = 1'b1;
               byte_val = {prev_ff[1:0], pop_entry.sextet};
            end
            default: begin
               emit     = 1'b0;
               byte_val = 8'd0;
            end
         endcase
      end
      if (pop_entry.last && pos_ff != 2'd3 && st == ST_OK) st = ST_LENGTH;

      // state update; drop back to the start after the last character
      pos_in    = pos_ff;
      prev_in   = prev_ff;
      sticky_in = sticky_ff;
      if (pop) begin
         if (pop_entry.last) begin
            pos_in      = 2'd0;
            prev_in     = 6'd0;
            pad_seen_in = 1'b0;
            sticky_in   = ST_OK;
         end else begin
            pos_in    = pos_ff + 2'd1;
            prev_in   = pop_entry.sextet;
            sticky_in = st;
         end
      end else begin
         pad_seen_in = pad_seen_ff;
      end

      // result register: hold until taken, load from the popped entry
      out_valid_in   = out_valid_ff && !rsp_tready;
      out_byte_in    = out_byte_ff;
      out_present_in = out_present_ff;
      out_last_in    = out_last_ff;
      out_status_in  = out_status_ff;
      if (pop && (emit || pop_entry.last)) begin
         out_valid_in   = 1'b1;
         out_byte_in    = byte_val;
         out_present_in = emit;
         out_last_in    = pop_entry.last;
         out_status_in  = st;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 2'd0;
         prev_ff      <= 6'd0;
         pad_seen_ff  <= 1'b0;
         sticky_ff    <= ST_OK;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         prev_ff      <= prev_in;
         pad_seen_ff  <= pad_seen_in;
         sticky_ff    <= sticky_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff    <= out_byte_in;
      out_present_ff <= out_present_in;
      out_last_ff    <= out_last_in;
      out_status_ff  <= out_status_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = {out_status_ff, out_present_ff};

endmodule

`default_nettype wire

// File: sv/base64_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit: streaming Base64 decoder, standard alphabet
// One character per request; emits a byte after the second, third and
// fourth character of each group of four unless it is '=', and reports
// end of message with a status on the character marked last.
// ----------------------------------------------------------------------------
//
//   channel  direction  payload
//   req_     in         tdata[7:0] char_code, tlast last_char
//   rsp_     out        tdata[7:0] data_byte, tlast end_of_message,
//                       tuser[0] byte_present, tuser[2:1] status
//
// Throughput is one character per clock while the queue has room; the back part
// consumes one queue entry per cycle while the result register is free or being drained.
// A request reaches the response through the queue and then the result register.
// Synchronous active-high reset empties the queue and clears decoder state.
// A stalled response holds; the two-entry queue keeps taking requests while the
// back part waits, until it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_decoder_unit import b64d_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] char_code
   input  wire logic       req_tlast,   // last_char
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] data_byte
   output logic            rsp_tlast,   // end_of_message
   output logic [2:0]      rsp_tuser    // [0] byte_present, [2:1] status
);

   logic      queue_full;
   logic      push_valid;
   entry_type push_entry;
   logic      pop;
   logic      pop_valid;
   entry_type pop_entry;

   // classify each incoming character
   b64d_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   // decouple intake from decoding
   b64d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   // advance the group state and register responses
   b64d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// File: tb/tb_base64_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_base64_stream_decoder_unit: self-checking bench of the Base64 decoder
// Sends a short directed table, then random messages, most of them well
// formed and the rest broken or noise. It predicts every response and
// compares it field by field with the oldest pending expectation, while the
// sender idles in bursts and the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_base64_stream_decoder_unit;
   import b64d_pkg::*;

   localparam int    RANDOM_ITEMS = 1000;
   localparam int    CYCLE_LIMIT  = 300000;
   localparam int    DRAIN_CYCLES = 10;
   localparam string ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   // one decoded response, as the rsp_ channel carries it
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
      status_type status;
   } decoded_type;

   // one character request; typed rows carry their response written out
   typedef struct packed {
      logic [7:0] code;
      logic       last;
      logic       typed;
      logic [7:0] t_byte;
      logic       t_present;
      logic       t_eom;
      status_type t_status;
   } char_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;   // [7:0] char_code
   logic       req_tlast = 1'b0;   // last_char
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;          // [7:0] data_byte
   logic       rsp_tlast;          // end_of_message
   logic [2:0] rsp_tuser;          // [0] byte_present, [2:1] status

   // predictor state: group position, previous sextet, pad flag, status
   logic [1:0]  grp_pos      = 2'd0;
   logic [5:0]  prev_sextet  = 6'd0;
   logic        pad_seen     = 1'b0;
   status_type  msg_status   = ST_OK;

   char_item_type char_queue[$];
   decoded_type   pending_decodes[$];
   int            mismatch_count = 0;
   int            cycle_count    = 0;
   int            burst_left     = 1;
   int            gap_left       = 0;
   int            ready_pct      = 100;
   int            ready_phase    = 0;

   // directed table; "=" is the pad, 00/FF/80 are outside the alphabet
   char_item_type directed_table [0:22] = '{
      '{8'h54, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},       // T
      '{8'h57, 1'b0, 1'b1, 8'h4D, 1'b1, 1'b0, ST_OK},       // W -> 'M'
      '{8'h46, 1'b0, 1'b1, 8'h61, 1'b1, 1'b0, ST_OK},       // F -> 'a'
      '{8'h75, 1'b1, 1'b1, 8'h6E, 1'b1, 1'b1, ST_OK},       // u -> 'n', end
      '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},       // lowest code
      '{8'hFF, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0, ST_ILLEGAL},
      '{8'h00, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0, ST_ILLEGAL},
      '{8'hFF, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, ST_ILLEGAL},
      '{8'h3D, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, ST_PADDING},  // lone pad, last
      '{8'h2F, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},       // /
      '{8'h2F, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b0, ST_OK},       // / -> all ones
      '{8'h3D, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},       // pad third place
      '{8'h3D, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, ST_OK},       // pad fourth, end
      '{8'h51, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},       // Q
      '{8'h51, 1'b0, 1'b1, 8'h41, 1'b1, 1'b0, ST_OK},       // Q -> 'A'
      '{8'h3D, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},       // pad third place
      '{8'h41, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},       // data after pad
      '{8'h51, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},       // Q
      '{8'h51, 1'b1, 1'b1, 8'h41, 1'b1, 1'b1, ST_LENGTH},   // short message
      '{8'h41, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},       // A
      '{8'h3D, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},       // pad second place
      '{8'h80, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK},       // later error held off
      '{8'h2B, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK}        // + , end
   };

   base64_stream_decoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   // keep the first error of a message
   function automatic void raise_status(input status_type code);
      if (msg_status == ST_OK) msg_status = code;
   endfunction

   // advance the predictor by one character; return 1 if a response is due
   function automatic bit decode_char(input logic [7:0] code, input logic last,
                                      output decoded_type res);
      logic [1:0] pos;
      logic [5:0] sx;
      logic [7:0] b;
      logic       emit;
      logic       hit;
      pos  = grp_pos;
      sx   = 6'd0;
      b    = 8'd0;
      emit = 1'b0;
      hit  = 1'b0;
      if (code == PAD_CODE) begin
         if (pos < 2'd2) raise_status(ST_PADDING);
         else pad_seen = 1'b1;
      end else begin
         for (int k = 0; k < 64; k++) begin
            if (!hit && ALPHABET[k] == code) begin
               sx  = k[5:0];
               hit = 1'b1;
            end
         end
         if (!hit) raise_status(ST_ILLEGAL);
         if (pad_seen) raise_status(ST_PADDING);
         case (pos)
            2'd1: b = {prev_sextet, sx[5:4]};
            2'd2: b = {prev_sextet[3:0], sx[5:2]};
            2'd3: b = {prev_sextet[1:0], sx};
            default: b = 8'd0;
         endcase
         emit = (pos != 2'd0);
      end
      prev_sextet = sx;
      grp_pos     = pos + 2'd1;
      if (last && pos != 2'd3) raise_status(ST_LENGTH);
      res.data_byte      = emit ? b : 8'd0;
      res.byte_present   = emit;
      res.end_of_message = last;
      res.status         = msg_status;
      // a finished message leaves the decoder as after reset
      if (last) begin
         grp_pos     = 2'd0;
         prev_sextet = 6'd0;
         pad_seen    = 1'b0;
         msg_status  = ST_OK;
      end
      return emit || last;
   endfunction

   // sender: predict each accepted request, then present the next one in
   // bursts of random length separated by random gaps
   always @(posedge clock) begin
      char_item_type it;
      decoded_type   res;
      bit            due;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            it  = char_queue.pop_front();
            due = decode_char(it.code, it.last, res);
            if (it.typed) begin
               res.data_byte      = it.t_byte;
               res.byte_present   = it.t_present;
               res.end_of_message = it.t_eom;
               res.status         = it.t_status;
               pending_decodes.push_back(res);
            end else if (due) begin
               pending_decodes.push_back(res);
            end
         end
         // hold a request that is still waiting; otherwise pick the next
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (char_queue.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= char_queue[0].code;
               req_tlast  <= char_queue[0].last;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 20);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall on stretches of changing density, some fully ready
   always @(posedge clock) begin
      if (ready_phase == 0) begin
         case ($urandom_range(0, 3))
            0: ready_pct = 100;
            1: ready_pct = 75;
            2: ready_pct = 40;
            default: ready_pct = 10;
         endcase
         ready_phase = $urandom_range(16, 96);
      end else begin
         ready_phase--;
      end
      rsp_tready <= ($urandom_range(0, 99) < ready_pct);
   end

   // checker: compare each accepted response with the oldest expectation
   always @(posedge clock) begin
      decoded_type got;
      decoded_type want;
      cycle_count++;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.data_byte      = rsp_tdata;
         got.byte_present   = rsp_tuser[0];
         got.end_of_message = rsp_tlast;
         got.status         = status_type'(rsp_tuser[2:1]);
         if (pending_decodes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: byte=%h present=%b eom=%b status=%0d",
                        got.data_byte, got.byte_present, got.end_of_message, got.status);
         end else begin
            want = pending_decodes.pop_front();
            if (got.data_byte !== want.data_byte || got.byte_present !== want.byte_present ||
                got.end_of_message !== want.end_of_message || got.status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected byte=%h present=%b eom=%b status=%0d, %s",
                           want.data_byte, want.byte_present, want.end_of_message,
                           want.status, $sformatf("got byte=%h present=%b eom=%b status=%0d",
                           got.data_byte, got.byte_present, got.end_of_message, got.status));
            end
         end
      end
   end

   // stimulus and end of run
   initial begin
      logic [7:0]    msg[$];
      char_item_type it;
      int            kind;
      int            nchars;
      int            k;
      for (k = 0; k < 23; k++) char_queue.push_back(directed_table[k]);
      // random messages: mostly well formed, then truncated, corrupted,
      // misplaced pads and pure noise
      while (char_queue.size() < RANDOM_ITEMS + 23) begin
         msg.delete();
         kind   = $urandom_range(0, 99);
         nchars = 4 * $urandom_range(1, 4);
         for (k = 0; k < nchars; k++) msg.push_back(ALPHABET[$urandom_range(0, 63)]);
         if (kind < 60) begin
            k = $urandom_range(0, 2);
            if (k >= 1) msg[nchars-1] = PAD_CODE;
            if (k == 2) msg[nchars-2] = PAD_CODE;
         end else if (kind < 70) begin
            repeat ($urandom_range(1, 3)) void'(msg.pop_back());
         end else if (kind < 80) begin
            msg[$urandom_range(0, nchars-1)] = 8'($urandom_range(0, 255));
         end else if (kind < 88) begin
            msg[$urandom_range(0, nchars-1)] = PAD_CODE;
         end else begin
            msg.delete();
            repeat ($urandom_range(1, 9)) msg.push_back(8'($urandom_range(0, 255)));
         end
         for (k = 0; k < msg.size(); k++) begin
            it      = '0;
            it.code = msg[k];
            it.last = (k == msg.size() - 1);
            char_queue.push_back(it);
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // drain: wait for every request to go out and every response to arrive
      while (cycle_count < CYCLE_LIMIT &&
             (char_queue.size() != 0 || req_tvalid || pending_decodes.size() != 0))
         @(posedge clock);
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[base64_stream_decoder_unit] ERROR");
      end else begin
         repeat (DRAIN_CYCLES) @(posedge clock);
         if (mismatch_count == 0 && pending_decodes.size() == 0) begin
            $display("[base64_stream_decoder_unit] OK");
         end else begin
            $display("[base64_stream_decoder_unit] ERROR");
         end
      end
      $finish;
   end

endmodule
